[src/lbns_pkg.sv]
package lbns_pkg;

  localparam int unsigned MaxNodes = 16;
  localparam int unsigned SlotW    = $clog2(MaxNodes);
  localparam int unsigned CountW   = $clog2(MaxNodes + 1);

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SET    = 2'd2,
    KIND_PICK   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STRAT_RR       = 2'd0,
    STRAT_WEIGHTED = 2'd1,
    STRAT_LEAST    = 2'd2,
    STRAT_UNIFORM  = 2'd3
  } strat_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NO_ACTIVE = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] node_addr;
    logic [15:0] node_port;
    logic [15:0] weight;
    logic        active_flag;
    logic [31:0] random_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  node_slot;
    logic [31:0] picked_addr;
    logic [15:0] picked_port;
  } out_item_t;

  // One table entry as it travels through the ring of cells
  typedef struct packed {
    logic [47:0] key;
    logic [15:0] weight;
    logic        active;
  } entry_t;

  // Per-cycle commands from the sequencer to every cell
  typedef struct packed {
    logic        rotate;   // shift ring by one position
    logic        wr_head;  // overwrite head with wr_entry
    logic        set_w;    // head: weight <- wr_entry.weight, active <- 1
    logic        set_act;  // head: active <- wr_entry.active
    logic        shift;    // ring at rest: close the gap of a removed slot
  } cell_ctl_t;

endpackage

[src/lbns_cell.sv]
// One storage cell of the rotating entry ring; loads from its neighbor
// on rotate or shift, the head cell also takes writes from the sequencer.
module lbns_cell import lbns_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      is_head_i,
  input  logic      shift_i,
  input  logic      clear_i,
  input  cell_ctl_t ctl_i,
  input  entry_t    wr_entry_i,
  input  entry_t    prev_i,
  output entry_t    entry_o
);

  logic [47:0] key_q;
  logic [15:0] weight_q;
  logic        act_q;
  entry_t      ent_d;

  assign entry_o = '{key: key_q, weight: weight_q, active: act_q};

  always_comb begin
    ent_d = entry_o;
    if (ctl_i.rotate || shift_i) begin
      ent_d = prev_i;
    end else if (clear_i) begin
      ent_d.active = 1'b0;
    end else if (is_head_i) begin
      if (ctl_i.wr_head) begin
        ent_d = wr_entry_i;
      end else if (ctl_i.set_w) begin
        ent_d.weight = wr_entry_i.weight;
        ent_d.active = 1'b1;
      end else if (ctl_i.set_act) begin
        ent_d.active = wr_entry_i.active;
      end
    end
  end

  // Payload needs no reset; active bit does
  always_ff @(posedge clk_i) begin
    key_q    <= ent_d.key;
    weight_q <= ent_d.weight;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      act_q <= ent_d.active;
    end
  end

endmodule

[src/lbns_ring.sv]
// Ring of MaxNodes cells. Cell 0 is the head, visible to the sequencer;
// rotating moves cell i+1 into cell i and the head around to the tail.
// With the ring at rest, a shift loads cells lo..hi-1 from the next cell up
// and clears the active bit of cell hi.
module lbns_ring import lbns_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctl_t        ctl_i,
  input  entry_t           wr_entry_i,
  input  logic [SlotW-1:0] shift_lo_i,
  input  logic [SlotW-1:0] shift_hi_i,
  output entry_t           head_o
);

  entry_t ent [MaxNodes];

  for (genvar g = 0; g < MaxNodes; g++) begin : g_cell
    logic take_next, drop;

    assign take_next = ctl_i.shift && SlotW'(g) >= shift_lo_i && SlotW'(g) < shift_hi_i;
    assign drop      = ctl_i.shift && SlotW'(g) == shift_hi_i;

    lbns_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .is_head_i  (g == 0),
      .shift_i    (take_next),
      .clear_i    (drop),
      .ctl_i      (ctl_i),
      .wr_entry_i (wr_entry_i),
      .prev_i     (ent[(g + 1) % MaxNodes]),
      .entry_o    (ent[g])
    );
  end

  assign head_o = ent[0];

endmodule

[src/lbns_divu.sv]
// Restoring divider, one quotient bit per cycle; gives remainder only.
module lbns_divu import lbns_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] rem_o
);

  logic [31:0] num_q, den_q, rem_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] trial;

  assign trial = {rem_q, num_q[31]} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[30:0], 1'b0};
      if (!trial[32]) begin
        rem_q <= trial[31:0];
      end else begin
        rem_q <= {rem_q[30:0], num_q[31]};
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[src/load_balance_node_selector.sv]
// Load-balancing node selector.
// Input channel in_valid_i/in_stall_o carries one in_item_t transaction:
// add/update, remove, set active bit or pick. Every transaction produces one
// out_item_t result on out_valid_o/out_stall_i (status, slot, address, port).
// The node table lives in a ring of 16 cells that rotates one position per
// cycle past a head cell during a sweep, but holds still for a head write.
// Sweep 1 matches the key, sums weights or counts active nodes and reduces
// the round-robin pointer; sweep 2 writes or picks at the head. Each sweep
// is a full turn, so slot order is restored. From acceptance the sequencer
// runs S_SCAN1, S_SCAN2, S_FIN and S_OUT before out_valid_o rises; a slot
// write pauses sweep 2, and weighted and uniform picks on a non-empty table
// run a 32-bit remainder divider between the sweeps. One transaction is
// handled at a time: the next one is accepted only once the result is taken.
// The strategy register is written on cfg_valid_i/cfg_ready_o while idle;
// a write also clears the round-robin pointer.
// Reset empties the table, clears pointer and strategy. While the receiver
// stalls, the result is held and in_stall_o stays high.
module load_balance_node_selector import lbns_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0] cfg_data_i
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN1  = 7'b0000010,
    S_DSTART = 7'b0000100,
    S_DIV    = 7'b0001000,
    S_SCAN2  = 7'b0010000,
    S_FIN    = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  in_item_t item_q;
  strat_e   strat_q;
  logic [CountW-1:0] count_q, count_d;
  logic [SlotW-1:0]  rr_q, rr_d;
  logic [SlotW-1:0]  pos_q;       // slot index currently at head
  logic [SlotW:0]    step_q;      // rotations done in this sweep
  logic              found_q;
  logic [SlotW-1:0]  fslot_q;
  logic [31:0]       total_q;     // active weight sum or active count
  logic [31:0]       acc_q;
  logic [31:0]       point_q;
  logic              picked_q;
  logic [SlotW-1:0]  pslot_q;
  logic [47:0]       pkey_q;
  logic [SlotW-1:0]  rrstart_q;
  logic [SlotW-1:0]  best_dist_q;
  logic              out_valid_q;
  out_item_t         out_q;
  logic              wr_phase_q;
  logic              div_start, div_done;
  logic [31:0]       div_rem;

  cell_ctl_t ctl;
  entry_t    wr_entry, head;

  logic        in_accept, in_live, kmatch, sweep_end, is_pick, table_full, do_write;
  kind_e       item_kind;
  logic [47:0] item_key;
  logic [31:0] inc, acc_next;
  logic [SlotW-1:0] rr_dist, last_slot;

  lbns_ring u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .wr_entry_i (wr_entry),
    .shift_lo_i (fslot_q),
    .shift_hi_i (last_slot),
    .head_o     (head)
  );

  lbns_divu u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (item_q.random_value),
    .den_i   (total_q),
    .done_o  (div_done),
    .rem_o   (div_rem)
  );

  assign item_kind  = kind_e'(item_q.kind);
  assign item_key   = {item_q.node_addr, item_q.node_port};
  assign in_live    = {1'b0, pos_q} < count_q;
  assign kmatch     = in_live && head.key == item_key;
  assign sweep_end  = step_q == (SlotW+1)'(MaxNodes - 1);
  assign is_pick    = item_kind == KIND_PICK;
  assign table_full = count_q == CountW'(MaxNodes);
  assign last_slot  = SlotW'(count_q - CountW'(1));
  assign inc        = (strat_q == STRAT_WEIGHTED) ? {16'd0, head.weight} : 32'd1;
  assign acc_next   = acc_q + inc;

  assign in_stall_o  = state_q != S_IDLE || out_valid_q;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = state_q == S_IDLE && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Round-robin candidate ordering: slots after start come first
  assign rr_dist = (pos_q > rrstart_q) ? pos_q - rrstart_q - 1'b1
                 : SlotW'(count_q - CountW'(rrstart_q) + CountW'(pos_q) - 1'b1);

  // Head write in sweep 2: the ring holds still while the target slot is at the head
  assign do_write = state_q == S_SCAN2 && !wr_phase_q && !is_pick &&
                    ((found_q && pos_q == fslot_q && item_kind != KIND_REMOVE) ||
                     (!found_q && item_kind == KIND_ADD && !table_full &&
                      {1'b0, pos_q} == count_q));

  // Sequencer: sweep 1 finds/counts, sweep 2 writes or picks
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    count_d   = count_q;
    rr_d      = rr_q;
    case (state_q)
      S_IDLE: begin
        if (cfg_valid_i && cfg_ready_o) rr_d = '0;
        if (in_accept) state_d = S_SCAN1;
      end
      S_SCAN1: begin
        if (sweep_end) begin
          if (is_pick && (strat_q == STRAT_WEIGHTED || strat_q == STRAT_UNIFORM)
              && count_q != '0) begin
            state_d = S_DSTART;
          end else begin
            state_d = S_SCAN2;
          end
        end
      end
      S_DSTART: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_d = S_SCAN2;
      end
      S_SCAN2: begin
        if (sweep_end && !do_write) state_d = S_FIN;
      end
      S_FIN: begin
        state_d = S_OUT;
        if (!is_pick) begin
          if (item_kind == KIND_ADD && !found_q && !table_full) begin
            count_d = count_q + 1'b1;
          end else if (item_kind == KIND_REMOVE && found_q) begin
            count_d = count_q - 1'b1;
          end
        end else if (count_q != '0 && strat_q == STRAT_RR) begin
          rr_d = picked_q ? pslot_q : rrstart_q;
        end
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Ring control: rotate while sweeping, write at head, close gap on remove
  always_comb begin
    ctl      = '0;
    wr_entry = '0;
    if (do_write) begin
      if (item_kind == KIND_ADD && found_q) begin
        ctl.set_w       = 1'b1;
        wr_entry.weight = item_q.weight;
      end else if (item_kind == KIND_ADD) begin
        ctl.wr_head = 1'b1;
        wr_entry    = '{key: item_key, weight: item_q.weight, active: 1'b1};
      end else begin
        ctl.set_act     = 1'b1;
        wr_entry.active = item_q.active_flag;
      end
    end else if (state_q == S_SCAN1 || state_q == S_SCAN2) begin
      ctl.rotate = 1'b1;
    end else if (state_q == S_FIN && item_kind == KIND_REMOVE && found_q) begin
      ctl.shift = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      strat_q     <= STRAT_RR;
      count_q     <= '0;
      rr_q        <= '0;
      out_valid_q <= 1'b0;
      wr_phase_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      rr_q       <= rr_d;
      wr_phase_q <= do_write;
      if (cfg_valid_i && cfg_ready_o) strat_q <= strat_e'(cfg_data_i);
      if (state_q == S_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Sweep bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      step_q <= '0;
    end else if (ctl.rotate) begin
      pos_q  <= pos_q + 1'b1;
      step_q <= sweep_end ? '0 : step_q + 1'b1;
    end else if (state_q != S_SCAN2) begin
      pos_q  <= '0;
      step_q <= '0;
    end
  end

  // Scan data path
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q      <= in_item_i;
      found_q     <= 1'b0;
      fslot_q     <= '0;
      total_q     <= '0;
      acc_q       <= '0;
      picked_q    <= 1'b0;
      pslot_q     <= '0;
      pkey_q      <= '0;
      best_dist_q <= '1;
      rrstart_q   <= rr_q;
    end
    if (state_q == S_SCAN1) begin
      // pointer mod count by repeated subtraction, done within the sweep
      if (count_q != '0 && {1'b0, rrstart_q} >= count_q)
        rrstart_q <= SlotW'({1'b0, rrstart_q} - count_q);
      if (kmatch && !found_q) begin
        found_q <= 1'b1;
        fslot_q <= pos_q;
      end
      if (in_live && head.active) total_q <= total_q + inc;
    end
    if (state_q == S_DIV && div_done) point_q <= div_rem;
    if (state_q == S_SCAN2 && is_pick && in_live && head.active) begin
      acc_q <= acc_next;
      case (strat_q)
        STRAT_RR: begin
          if (!picked_q || rr_dist < best_dist_q) begin
            best_dist_q <= rr_dist;
            picked_q <= 1'b1;
            pslot_q  <= pos_q;
            pkey_q   <= head.key;
          end
        end
        STRAT_WEIGHTED, STRAT_LEAST: begin
          if (!picked_q && (strat_q == STRAT_LEAST || acc_next > point_q)) begin
            picked_q <= 1'b1;
            pslot_q  <= pos_q;
            pkey_q   <= head.key;
          end
        end
        STRAT_UNIFORM: begin
          if (!picked_q && acc_q == point_q) begin
            picked_q <= 1'b1;
            pslot_q  <= pos_q;
            pkey_q   <= head.key;
          end
        end
        default: ;
      endcase
    end
    // Result built while the count still holds its value before this item
    if (state_q == S_FIN) begin
      out_q <= '0;
      if (is_pick) begin
        if (count_q == '0) out_q.status <= ST_EMPTY;
        else if (!picked_q || (strat_q == STRAT_WEIGHTED && total_q == '0))
          out_q.status <= ST_NO_ACTIVE;
        else begin
          out_q.status      <= ST_OK;
          out_q.node_slot   <= 4'(pslot_q);
          out_q.picked_addr <= pkey_q[47:16];
          out_q.picked_port <= pkey_q[15:0];
        end
      end else if (item_kind == KIND_ADD && !found_q && table_full) begin
        out_q.status <= ST_FULL;
      end
    end
  end

endmodule

[sim/load_balance_node_selector_tb.sv]
`timescale 1ns / 100ps

module load_balance_node_selector_tb;
  import lbns_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [1:0] cfg_data_i;

  load_balance_node_selector uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  localparam int WatchdogLimit = 20000;

  // Table shadow
  logic [47:0] tbl_key    [MaxNodes];
  logic [15:0] tbl_weight [MaxNodes];
  logic        tbl_active [MaxNodes];
  int unsigned tbl_count;
  int unsigned rr_ptr;
  strat_e      cur_strat;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int  errors;
  int  picks_ok;
  int  results_seen;
  int  idle_cycles;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  driving_done;

  // Address pool so adds, removes and sets hit existing nodes often
  logic [31:0] pool_addr [24];
  logic [15:0] pool_port [24];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int find_node(logic [47:0] key);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_key[i] == key) return i;
    return -1;
  endfunction

  // Selection of one node under the current strategy; -1 when nothing qualifies
  function automatic int select_node(logic [31:0] rnd);
    int unsigned start;
    int unsigned idx;
    longint unsigned total;
    longint unsigned acc;
    longint unsigned point;
    int unsigned n;
    int unsigned k;
    case (cur_strat)
      STRAT_RR: begin
        start = rr_ptr % tbl_count;
        for (int i = 1; i <= tbl_count; i++) begin
          idx = (start + i) % tbl_count;
          if (tbl_active[idx]) begin
            rr_ptr = idx;
            return idx;
          end
        end
        rr_ptr = start;
        return -1;
      end
      STRAT_WEIGHTED: begin
        total = 0;
        acc = 0;
        for (int i = 0; i < tbl_count; i++)
          if (tbl_active[i]) total += tbl_weight[i];
        if (total == 0) return -1;
        point = rnd % total;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_active[i]) begin
            acc += tbl_weight[i];
            if (acc > point) return i;
          end
        end
        return -1;
      end
      STRAT_LEAST: begin
        for (int i = 0; i < tbl_count; i++)
          if (tbl_active[i]) return i;
        return -1;
      end
      default: begin
        n = 0;
        for (int i = 0; i < tbl_count; i++)
          if (tbl_active[i]) n++;
        if (n == 0) return -1;
        k = rnd % n;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_active[i]) begin
            if (k == 0) return i;
            k--;
          end
        end
        return -1;
      end
    endcase
  endfunction

  // Apply one transaction to the shadow table and queue its result
  task automatic predict_selector(in_item_t it);
    out_item_t   res;
    logic [47:0] key;
    int          slot;
    res = '0;
    res.status = ST_OK;
    key = {it.node_addr, it.node_port};
    case (kind_e'(it.kind))
      KIND_ADD: begin
        slot = find_node(key);
        if (slot >= 0) begin
          tbl_weight[slot] = it.weight;
          tbl_active[slot] = 1'b1;
        end else if (tbl_count < MaxNodes) begin
          tbl_key[tbl_count]    = key;
          tbl_weight[tbl_count] = it.weight;
          tbl_active[tbl_count] = 1'b1;
          tbl_count++;
        end else begin
          res.status = ST_FULL;
        end
      end
      KIND_REMOVE: begin
        slot = find_node(key);
        if (slot >= 0) begin
          for (int i = slot; i + 1 < tbl_count; i++) begin
            tbl_key[i]    = tbl_key[i+1];
            tbl_weight[i] = tbl_weight[i+1];
            tbl_active[i] = tbl_active[i+1];
          end
          tbl_count--;
          tbl_active[tbl_count] = 1'b0;
        end
      end
      KIND_SET: begin
        slot = find_node(key);
        if (slot >= 0) tbl_active[slot] = it.active_flag;
      end
      default: begin
        if (tbl_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          slot = select_node(it.random_value);
          if (slot < 0) begin
            res.status = ST_NO_ACTIVE;
          end else begin
            res.node_slot   = slot[3:0];
            res.picked_addr = tbl_key[slot][47:16];
            res.picked_port = tbl_key[slot][15:0];
          end
        end
      end
    endcase
    expected_results.insert(expected_results.size(), res);
  endtask

  task automatic queue_item(in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic in_item_t make_item(kind_e k, logic [31:0] a, logic [15:0] p,
                                         logic [15:0] w, logic af, logic [31:0] r);
    in_item_t it;
    it.kind = k;
    it.node_addr = a;
    it.node_port = p;
    it.weight = w;
    it.active_flag = af;
    it.random_value = r;
    return it;
  endfunction

  function automatic in_item_t random_item();
    int sel;
    int pick_pct;
    logic [31:0] a;
    logic [15:0] p;
    logic [15:0] w;
    sel = int'($urandom_range(23));
    a = pool_addr[sel];
    p = pool_port[sel];
    // Occasional node outside the pool
    if ($urandom_range(9) == 0) begin
      a = $urandom;
      p = 16'($urandom);
    end
    case ($urandom_range(3))
      0: w = 16'd0;
      1: w = 16'hffff;
      default: w = 16'($urandom_range(40));
    endcase
    if ($urandom_range(4) == 0) w = 16'($urandom);
    pick_pct = int'($urandom_range(99));
    if (pick_pct < 40)
      return make_item(KIND_PICK, a, p, w, 1'($urandom), $urandom);
    else if (pick_pct < 65)
      return make_item(KIND_ADD, a, p, w, 1'($urandom), $urandom);
    else if (pick_pct < 80)
      return make_item(KIND_REMOVE, a, p, w, 1'($urandom), $urandom);
    else
      return make_item(KIND_SET, a, p, w, $urandom_range(99) < 60, $urandom);
  endfunction

  // Input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      // Previous transaction accepted or slot empty
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item_i  <= pending_items[0];
        predict_selector(pending_items.pop_front());
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $realtime, out_item_o);
          errors++;
        end else begin
          if (out_item_o !== expected_results[0]) begin
            $display("%0t: mismatch expected %p actual %p", $realtime,
                     expected_results[0], out_item_o);
            errors++;
          end else if (out_item_o.status == ST_OK &&
                       expected_results[0].picked_addr != 0) begin
            picks_ok++;
          end
          void'(expected_results.pop_front());
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog on accepted transactions
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("watchdog expired, %0d results outstanding", expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic drain();
    while (pending_items.size() > 0 || expected_results.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_strategy(strat_e s);
    @(posedge clk_i);
    cfg_data_i  <= s;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_strat = s;
    rr_ptr = 0;
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) queue_item(random_item());
  endtask

  initial begin
    errors = 0;
    picks_ok = 0;
    results_seen = 0;
    idle_cycles = 0;
    tbl_count = 0;
    rr_ptr = 0;
    cur_strat = STRAT_RR;
    for (int i = 0; i < MaxNodes; i++) begin
      tbl_key[i] = '0;
      tbl_weight[i] = '0;
      tbl_active[i] = 1'b0;
    end
    for (int i = 0; i < 24; i++) begin
      pool_addr[i] = (i < 2) ? {32{i[0]}} : $urandom;
      pool_port[i] = (i < 2) ? {16{i[0]}} : 16'($urandom);
    end
    send_idle_pct = 12;
    recv_idle_pct = 50;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty pick, extremes, fill past full, removes and status changes
    queue_item(make_item(KIND_PICK, '0, '0, '0, 1'b0, '0));
    queue_item(make_item(KIND_ADD, '0, '0, '0, 1'b0, '1));
    queue_item(make_item(KIND_ADD, '1, '1, '1, 1'b1, '0));
    queue_item(make_item(KIND_PICK, '0, '0, '0, 1'b0, '1));
    queue_item(make_item(KIND_PICK, '0, '0, '0, 1'b0, '0));
    for (int i = 0; i < 15; i++)
      queue_item(make_item(KIND_ADD, 32'(32'h1000 + i), 16'(i), 16'(i), 1'b0, '0));
    queue_item(make_item(KIND_ADD, '1, '1, 16'd7, 1'b0, '0));
    queue_item(make_item(KIND_REMOVE, '0, '0, '0, 1'b0, '0));
    queue_item(make_item(KIND_REMOVE, 32'hdead, 16'h1, '0, 1'b0, '0));
    queue_item(make_item(KIND_SET, '1, '1, '0, 1'b0, '0));
    queue_item(make_item(KIND_PICK, '0, '0, '0, 1'b1, '1));
    drain();

    // Per strategy: random traffic with the three idling profiles
    for (int s = 0; s < 4; s++) begin
      write_strategy(strat_e'(s));
      send_idle_pct = 12; recv_idle_pct = 50;
      run_random(90);
      drain();
      send_idle_pct = 50; recv_idle_pct = 12;
      run_random(90);
      drain();
      send_idle_pct = 0; recv_idle_pct = 0;
      run_random(70);
      // All pool nodes set inactive in one go, then pick
      for (int i = 0; i < 24; i++)
        queue_item(make_item(KIND_SET, pool_addr[i], pool_port[i], '0, 1'b0, '0));
      queue_item(make_item(KIND_PICK, '0, '0, '0, 1'b0, $urandom));
      drain();
    end
    write_strategy(STRAT_RR);
    run_random(40);
    drain();

    $display("covered %0d results across all four strategies and three idle profiles",
             results_seen);
    $display("%0d successful picks, table full, empty and no-active cases included", picks_ok);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
src/lbns_pkg.sv
src/lbns_cell.sv
src/lbns_ring.sv
src/lbns_divu.sv
src/load_balance_node_selector.sv
sim/load_balance_node_selector_tb.sv
